FILE: src/fsc_pkg.sv
// ----------------------------------------------------------------------------
// fsc_pkg
// Shared types and constants for the frequency stability checker.
// ----------------------------------------------------------------------------
package fsc_pkg;

    localparam int COUNT_W = 16;
    localparam int FREQ_W  = 22;
    localparam int ROC_W   = 24;
    localparam int CFG_W   = 24;
    localparam int IDX_W   = 2;

    // Divider geometry: the rate dividend is |df| * 32000, 22 + 15 bits.
    localparam int DVD_W  = 37;
    localparam int DSR_W  = COUNT_W + 1;
    localparam int STEP_W = 6;

    localparam logic [FREQ_W-1:0] FREQ_MAX  = {FREQ_W{1'b1}};
    localparam logic [ROC_W-1:0]  ROC_MAX   = {ROC_W{1'b1}};
    localparam logic [FREQ_W-1:0] FREQ_NUM  = FREQ_W'(16000 * 256);
    localparam logic [15:0]       RATE_MULT = 16'd32000;

    localparam logic [STEP_W-1:0] FREQ_STEPS = STEP_W'(FREQ_W);
    localparam logic [STEP_W-1:0] RATE_STEPS = STEP_W'(DVD_W);

    localparam logic [IDX_W-1:0] REG_LOW_FREQ = 2'd0;
    localparam logic [IDX_W-1:0] REG_ROC_LIM  = 2'd1;

    localparam logic [FREQ_W-1:0] LOW_FREQ_RESET = 22'd12544;
    localparam logic [ROC_W-1:0]  ROC_LIM_RESET  = 24'd2304;

    typedef struct packed {
        logic              start;
        logic [DVD_W-1:0]  dividend;
        logic [DSR_W-1:0]  divisor;
        logic [STEP_W-1:0] steps;
    } div_ctrl_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } div_stat_t;

endpackage

FILE: src/fsc_divider.sv
// ----------------------------------------------------------------------------
// fsc_divider
// Restoring divider, one quotient bit per clock, shared by both divisions.
// ----------------------------------------------------------------------------
module fsc_divider
    import fsc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  div_ctrl_t ctrl,
    output div_stat_t stat
);

    logic [DSR_W:0]    rem_reg, rem_next;
    logic [DVD_W-1:0]  dvd_reg, dvd_next;
    logic [DVD_W-1:0]  quo_reg, quo_next;
    logic [DSR_W-1:0]  dsr_reg, dsr_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [DSR_W:0] trial;
    logic [DSR_W:0] shifted;

    always_comb
    begin
        shifted   = {rem_reg[DSR_W-1:0], dvd_reg[DVD_W-1]};
        trial     = shifted - {1'b0, dsr_reg};
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctrl.start)
        begin
            rem_next  = '0;
            dvd_next  = ctrl.dividend;
            quo_next  = '0;
            dsr_next  = ctrl.divisor;
            cnt_next  = ctrl.steps;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            if (shifted >= {1'b0, dsr_reg})
            begin
                rem_next = trial;
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign stat.done     = done_reg;
    assign stat.quotient = quo_reg;

endmodule

FILE: src/frequency_stability_checker_core.sv
// ----------------------------------------------------------------------------
// frequency_stability_checker_core
// Under-frequency and rate-of-change check on a stream of period counts.
// ----------------------------------------------------------------------------
// Each input request carries one period count of the supply signal in ticks of
// a 16000 Hz sample clock. The block answers every request with one result:
// the frequency 4096000 / count and the absolute rate of change
// |f_new - f_old| * 32000 / (count_new + count_old), both unsigned with eight
// fraction bits and truncated, an unstable flag and the count itself. A zero
// count gives the all-ones frequency, and a zero in either count gives the
// all-ones rate, so the first result after reset reports unstable unless the
// rate limit is all ones. Both divisions run on one shared restoring divider
// that produces one quotient bit per clock, 22 bits for the frequency and 37
// for the rate. A request passes through the states FREQ_START, FREQ_WAIT,
// DIFF, MUL, RATE_START, RATE_WAIT and FINISH; the rate division is skipped
// when only the previous count is zero, and both divisions are skipped when
// the new count is zero. The next request can be accepted in the cycle after
// the result is loaded. The input is ready only while the sequencer is idle;
// the result sits in an output register, so a new request is accepted while
// the previous result still waits to be taken. The limit registers are
// written through the plain write port and should be changed only when idle.
// ----------------------------------------------------------------------------
module frequency_stability_checker_core
    import fsc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,

    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [15:0]      s_tdata,   // [15:0] period_count

    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [63:0]      m_tdata,   // [21:0] frequency_q8, [45:22] roc_q8,
                                        // [46] unstable, [62:47] count_echo, [63] zero

    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FREQ_START,
        ST_FREQ_WAIT,
        ST_DIFF,
        ST_MUL,
        ST_RATE_START,
        ST_RATE_WAIT,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    // Limit registers.
    logic [FREQ_W-1:0] low_lim_reg;
    logic [ROC_W-1:0]  roc_lim_reg;

    // History kept from the previous request. The frequency of the previous
    // count is kept too, so that it need not be divided out again.
    logic [COUNT_W-1:0] prev_count_reg, prev_count_next;
    logic [FREQ_W-1:0]  prev_freq_reg, prev_freq_next;

    // Working registers of the current request.
    logic [COUNT_W-1:0] cnew_reg, cnew_next;
    logic [FREQ_W-1:0]  fnew_reg, fnew_next;
    logic [ROC_W-1:0]   roc_reg, roc_next;
    logic [FREQ_W-1:0]  diff_reg, diff_next;
    logic [DVD_W-1:0]   prod_reg, prod_next;
    logic [DSR_W-1:0]   sum_reg, sum_next;

    // Result register.
    logic        out_valid_reg, out_valid_next;
    logic [63:0] out_data_reg, out_data_next;

    div_ctrl_t div_ctrl;
    div_stat_t div_stat;

    logic in_fire;
    logic out_free;
    logic unstable;

    fsc_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (div_ctrl),
        .stat  (div_stat)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign unstable = (fnew_reg < low_lim_reg) || (roc_reg > roc_lim_reg);

    always_comb
    begin
        state_next      = state_reg;
        prev_count_next = prev_count_reg;
        prev_freq_next  = prev_freq_reg;
        cnew_next       = cnew_reg;
        fnew_next       = fnew_reg;
        roc_next        = roc_reg;
        diff_next       = diff_reg;
        prod_next       = prod_reg;
        sum_next        = sum_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;

        div_ctrl.start    = 1'b0;
        div_ctrl.dividend = {FREQ_NUM, {(DVD_W-FREQ_W){1'b0}}};
        div_ctrl.divisor  = {1'b0, cnew_reg};
        div_ctrl.steps    = FREQ_STEPS;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cnew_next  = s_tdata[COUNT_W-1:0];
                    state_next = ST_FREQ_START;
                end
            end
            ST_FREQ_START:
            begin
                if (cnew_reg == '0)
                begin
                    // Infinite frequency: saturate both values.
                    fnew_next  = FREQ_MAX;
                    roc_next   = ROC_MAX;
                    state_next = ST_FINISH;
                end
                else
                begin
                    div_ctrl.start = 1'b1;
                    state_next     = ST_FREQ_WAIT;
                end
            end
            ST_FREQ_WAIT:
            begin
                if (div_stat.done)
                begin
                    fnew_next = div_stat.quotient[FREQ_W-1:0];
                    if (prev_count_reg == '0)
                    begin
                        roc_next   = ROC_MAX;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_DIFF;
                    end
                end
            end
            ST_DIFF:
            begin
                if (fnew_reg > prev_freq_reg)
                begin
                    diff_next = fnew_reg - prev_freq_reg;
                end
                else
                begin
                    diff_next = prev_freq_reg - fnew_reg;
                end
                sum_next   = {1'b0, cnew_reg} + {1'b0, prev_count_reg};
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                prod_next  = DVD_W'(diff_reg) * DVD_W'(RATE_MULT);
                state_next = ST_RATE_START;
            end
            ST_RATE_START:
            begin
                div_ctrl.start    = 1'b1;
                div_ctrl.dividend = prod_reg;
                div_ctrl.divisor  = sum_reg;
                div_ctrl.steps    = RATE_STEPS;
                state_next        = ST_RATE_WAIT;
            end
            ST_RATE_WAIT:
            begin
                if (div_stat.done)
                begin
                    if (div_stat.quotient[DVD_W-1:ROC_W] != '0)
                    begin
                        roc_next = ROC_MAX;
                    end
                    else
                    begin
                        roc_next = div_stat.quotient[ROC_W-1:0];
                    end
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // Hold the finished result until the output register is free.
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_data_next   = {1'b0, cnew_reg, unstable, roc_reg, fnew_reg};
                    prev_count_next = cnew_reg;
                    prev_freq_next  = fnew_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            prev_count_reg <= '0;
            low_lim_reg    <= LOW_FREQ_RESET;
            roc_lim_reg    <= ROC_LIM_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            prev_count_reg <= prev_count_next;
            if (cfg_we && (cfg_index == REG_LOW_FREQ))
            begin
                low_lim_reg <= cfg_data[FREQ_W-1:0];
            end
            if (cfg_we && (cfg_index == REG_ROC_LIM))
            begin
                roc_lim_reg <= cfg_data[ROC_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prev_freq_reg <= prev_freq_next;
        cnew_reg      <= cnew_next;
        fnew_reg      <= fnew_next;
        roc_reg       <= roc_next;
        diff_reg      <= diff_next;
        prod_reg      <= prod_next;
        sum_reg       <= sum_next;
        out_data_reg  <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
